/* rtl/mlc_pkg.sv */
package mlc_pkg;

    // Widths of the node ids and of the line address.
    localparam int NODE_ID_BITS = 4;
    localparam int ADDR_BITS    = 32;

    // Line states, stable first and then the transients.
    typedef enum logic [3:0] {
        ST_I  = 4'd0,
        ST_S  = 4'd1,
        ST_E  = 4'd2,
        ST_O  = 4'd3,
        ST_M  = 4'd4,
        ST_F  = 4'd5,
        ST_IS = 4'd6,
        ST_IM = 4'd7,
        ST_SM = 4'd8,
        ST_OM = 4'd9,
        ST_FM = 4'd10
    } line_state_t;

    // Message codes. The three remaining codes are illegal.
    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_STORE = 3'd1,
        OP_GETS  = 3'd2,
        OP_GETM  = 3'd3,
        OP_DATA  = 3'd4
    } op_t;

    // Bus request codes.
    typedef enum logic [1:0] {
        REQ_NONE = 2'd0,
        REQ_GETS = 2'd1,
        REQ_GETM = 2'd2
    } bus_req_t;

    // One incoming message as held in the input register.
    typedef struct packed {
        logic [2:0]              operation;
        logic [ADDR_BITS-1:0]    line_address;
        logic [NODE_ID_BITS-1:0] source_node;
        logic [NODE_ID_BITS-1:0] dest_node;
        logic                    shared_in;
    } msg_t;

    // One result as held in the result register.
    typedef struct packed {
        bus_req_t                bus_request;
        logic                    data_to_proc;
        logic                    data_on_bus;
        logic [NODE_ID_BITS-1:0] data_target;
        logic [ADDR_BITS-1:0]    addr_out;
        logic                    assert_shared;
        logic                    protocol_error;
        logic                    miss_event;
        logic                    silent_upgrade;
        logic                    transfer_event;
        line_state_t             line_state;
    } result_t;

endpackage

/* rtl/mlc_in_reg.sv */
module mlc_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mlc_pkg::msg_t in_msg,
    input  logic          take,
    output logic          held_valid,
    output mlc_pkg::msg_t held_msg
);
    import mlc_pkg::*;

    logic valid_reg;
    logic valid_next;
    msg_t msg_reg;

    // The register refills in the same cycle that its content moves on.
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            msg_reg <= in_msg;
        end
    end

    assign held_valid = valid_reg;
    assign held_msg   = msg_reg;

endmodule

/* rtl/mlc_transition.sv */
module mlc_transition (
    input  mlc_pkg::line_state_t               cur_state,
    input  mlc_pkg::msg_t                      msg,
    input  logic [mlc_pkg::NODE_ID_BITS-1:0]   own_id,
    output mlc_pkg::result_t                   res
);
    import mlc_pkg::*;

    line_state_t st;
    bus_req_t    req;
    logic        to_proc;
    logic        on_bus;
    logic        assert_sh;
    logic        err;
    logic        miss;
    logic        upgrade;
    logic        xfer;
    logic        for_me;

    assign for_me = (msg.dest_node == own_id);

    always_comb
    begin
        st        = cur_state;
        req       = REQ_NONE;
        to_proc   = 1'b0;
        on_bus    = 1'b0;
        assert_sh = 1'b0;
        err       = 1'b0;
        miss      = 1'b0;
        upgrade   = 1'b0;
        xfer      = 1'b0;

        case (op_t'(msg.operation))
            OP_LOAD, OP_STORE:
            begin
                case (cur_state)
                    ST_S, ST_O, ST_F:
                    begin
                        if (msg.operation == OP_STORE)
                        begin
                            req  = REQ_GETM;
                            miss = 1'b1;
                            st   = (cur_state == ST_S) ? ST_SM :
                                   (cur_state == ST_O) ? ST_OM : ST_FM;
                        end
                        else
                        begin
                            to_proc = 1'b1;
                        end
                    end
                    ST_E:
                    begin
                        to_proc = 1'b1;
                        if (msg.operation == OP_STORE)
                        begin
                            st      = ST_M;
                            upgrade = 1'b1;
                        end
                    end
                    ST_M:
                    begin
                        to_proc = 1'b1;
                    end
                    ST_IS, ST_IM, ST_SM, ST_OM, ST_FM:
                    begin
                        err = 1'b1;
                    end
                    default:
                    begin
                        // Invalid: a miss that starts a transaction.
                        miss = 1'b1;
                        if (msg.operation == OP_STORE)
                        begin
                            req = REQ_GETM;
                            st  = ST_IM;
                        end
                        else
                        begin
                            req = REQ_GETS;
                            st  = ST_IS;
                        end
                    end
                endcase
            end
            OP_GETS, OP_GETM:
            begin
                case (cur_state)
                    ST_S:
                    begin
                        if (msg.operation == OP_GETM)
                        begin
                            st = ST_I;
                        end
                        else
                        begin
                            assert_sh = 1'b1;
                        end
                    end
                    ST_M, ST_E, ST_O, ST_F:
                    begin
                        on_bus = 1'b1;
                        xfer   = 1'b1;
                        if (msg.operation == OP_GETM)
                        begin
                            st = ST_I;
                        end
                        else
                        begin
                            assert_sh = 1'b1;
                            if (cur_state == ST_M)
                            begin
                                st = ST_O;
                            end
                            else if (cur_state == ST_E)
                            begin
                                st = ST_F;
                            end
                        end
                    end
                    ST_OM, ST_FM:
                    begin
                        on_bus = 1'b1;
                        xfer   = 1'b1;
                        if (msg.operation == OP_GETM)
                        begin
                            st = ST_IM;
                        end
                        else
                        begin
                            assert_sh = 1'b1;
                        end
                    end
                    default:
                    begin
                        st = cur_state;
                    end
                endcase
            end
            OP_DATA:
            begin
                case (cur_state)
                    ST_M:
                    begin
                        err = 1'b1;
                    end
                    ST_IS:
                    begin
                        if (for_me)
                        begin
                            to_proc = 1'b1;
                            st      = msg.shared_in ? ST_S : ST_E;
                        end
                    end
                    ST_IM, ST_SM, ST_OM, ST_FM:
                    begin
                        if (for_me)
                        begin
                            to_proc = 1'b1;
                            st      = ST_M;
                        end
                    end
                    default:
                    begin
                        st = cur_state;
                    end
                endcase
            end
            default:
            begin
                err = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        res.bus_request    = req;
        res.data_to_proc   = to_proc;
        res.data_on_bus    = on_bus;
        res.data_target    = on_bus ? msg.source_node : '0;
        res.addr_out       = ((req != REQ_NONE) || to_proc || on_bus) ? msg.line_address : '0;
        res.assert_shared  = assert_sh;
        res.protocol_error = err;
        res.miss_event     = miss;
        res.silent_upgrade = upgrade;
        res.transfer_event = xfer;
        res.line_state     = st;
    end

endmodule

/* rtl/moesif_line_coherence_fsm_unit.sv */
// Coherence controller for one cache line under a snooping MOESIF protocol.
// Each transfer on the input channel carries one message, a processor LOAD or
// STORE or a snooped GETS, GETM or DATA, and yields exactly one transfer on the
// output channel, in order. The output tells which bus request to issue,
// whether data goes to the processor or onto the bus (and to which node),
// whether the shared line is asserted, which miss, silent-upgrade and
// cache-to-cache events occurred, and the line state after the message.
// Messages that are illegal in the current state raise protocol_error and
// leave the state unchanged. A message passes through an input register and
// the next-state logic into the result register, and one message is taken
// every cycle as long as results are taken. The line state is updated as a
// result is loaded, so back-to-back messages always see the state left by the
// previous one. own_node_id is written through cfg_we and cfg_wdata; the user
// must write it only while no message is in flight, as the block does not
// enforce this. It resets to zero, and the line resets to Invalid.
module moesif_line_coherence_fsm_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mlc_pkg::NODE_ID_BITS-1:0]  cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        operation,
    input  logic [mlc_pkg::ADDR_BITS-1:0]     line_address,
    input  logic [mlc_pkg::NODE_ID_BITS-1:0]  source_node,
    input  logic [mlc_pkg::NODE_ID_BITS-1:0]  dest_node,
    input  logic                              shared_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        bus_request,
    output logic                              data_to_proc,
    output logic                              data_on_bus,
    output logic [mlc_pkg::NODE_ID_BITS-1:0]  data_target,
    output logic [mlc_pkg::ADDR_BITS-1:0]     addr_out,
    output logic                              assert_shared,
    output logic                              protocol_error,
    output logic                              miss_event,
    output logic                              silent_upgrade,
    output logic                              transfer_event,
    output logic [3:0]                        line_state
);
    import mlc_pkg::*;

    logic [NODE_ID_BITS-1:0] own_id_reg;
    line_state_t             state_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    result_t                 result_reg;

    msg_t    in_msg;
    msg_t    held_msg;
    logic    held_valid;
    logic    advance;
    result_t step_res;

    assign in_msg.operation    = operation;
    assign in_msg.line_address = line_address;
    assign in_msg.source_node  = source_node;
    assign in_msg.dest_node    = dest_node;
    assign in_msg.shared_in    = shared_in;

    // A held message moves on whenever the result register is empty or its
    // result is being taken in this cycle.
    assign advance = held_valid && (!out_valid_reg || out_ready);

    mlc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_msg     (in_msg),
        .take       (advance),
        .held_valid (held_valid),
        .held_msg   (held_msg)
    );

    mlc_transition u_transition (
        .cur_state (state_reg),
        .msg       (held_msg),
        .own_id    (own_id_reg),
        .res       (step_res)
    );

    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Control state: node id, line state and the result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg    <= '0;
            state_reg     <= ST_I;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                own_id_reg <= cfg_wdata;
            end
            if (advance)
            begin
                state_reg <= step_res.line_state;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // The result payload needs no reset; it is qualified by out_valid.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign bus_request    = result_reg.bus_request;
    assign data_to_proc   = result_reg.data_to_proc;
    assign data_on_bus    = result_reg.data_on_bus;
    assign data_target    = result_reg.data_target;
    assign addr_out       = result_reg.addr_out;
    assign assert_shared  = result_reg.assert_shared;
    assign protocol_error = result_reg.protocol_error;
    assign miss_event     = result_reg.miss_event;
    assign silent_upgrade = result_reg.silent_upgrade;
    assign transfer_event = result_reg.transfer_event;
    assign line_state     = result_reg.line_state;

    // The state register always agrees with the newest result that is shown.
    a_state_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.line_state == state_reg))
        else $error("line state register disagrees with the pending result");

    // A message never moves into an occupied result register that is stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && out_valid_reg && !out_ready))
        else $error("result overwritten before its transfer");

    // A silent upgrade always ends in M.
    a_upgrade_to_m: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.silent_upgrade) |-> (result_reg.line_state == ST_M))
        else $error("silent upgrade without a move to M");

    // Any bus request is issued only on a processor miss.
    a_request_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.bus_request != REQ_NONE)) |-> result_reg.miss_event)
        else $error("bus request without a miss");

endmodule

/* dv/tb.sv */
// Checks the single-line MOESIF coherence controller. Message sequences are
// pushed through the valid/ready input channel. A predictor in this bench works
// out each expected result, and the results that come out of the block are
// checked against it, field by field and in order.
//
// Stimulus runs in phases. A directed phase walks the line through every
// stable and transient state, and through each illegal-message case. Random
// phases follow. Most random traffic is built as coherence transactions: a
// processor access, up to two snooped requests, then the DATA that completes
// the miss. The rest is standalone snoops and noise, with every operation code
// possible. own_node_id is rewritten between phases, only once the block has
// drained. Both extremes of the node id are used.
module tb;

    import mlc_pkg::*;

    // Codes 5 to 7 are not defined messages; the block must flag them.
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_LEN    = 300;
    localparam int MAX_REPORTS = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = '0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  operation = '0;
    logic [31:0] line_address = '0;
    logic [3:0]  source_node = '0;
    logic [3:0]  dest_node = '0;
    logic        shared_in = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  bus_request;
    logic        data_to_proc;
    logic        data_on_bus;
    logic [3:0]  data_target;
    logic [31:0] addr_out;
    logic        assert_shared;
    logic        protocol_error;
    logic        miss_event;
    logic        silent_upgrade;
    logic        transfer_event;
    logic [3:0]  line_state;

    // Messages that are waiting to be offered, and the results that are
    // owed for messages already transferred, oldest first.
    msg_t        pending_msgs[$];
    result_t     owed_results[$];

    // The predictor's own copy of the line state and of the node id.
    line_state_t line_coh_state = ST_I;
    logic [3:0]  line_node_id = '0;

    msg_t        cur_msg;
    result_t     predicted_res;
    result_t     want;

    // Idling knobs, in percent, changed only between phases.
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // The long receiver hold-off used to back the block up.
    logic        hold_req = 1'b0;
    int          hold_cnt = 0;
    logic        long_hold;

    int          n_fail = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_in_stalls = 0;
    int          cycle_cnt = 0;
    logic [10:0] states_seen = '0;

    moesif_line_coherence_fsm_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .line_address   (line_address),
        .source_node    (source_node),
        .dest_node      (dest_node),
        .shared_in      (shared_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .bus_request    (bus_request),
        .data_to_proc   (data_to_proc),
        .data_on_bus    (data_on_bus),
        .data_target    (data_target),
        .addr_out       (addr_out),
        .assert_shared  (assert_shared),
        .protocol_error (protocol_error),
        .miss_event     (miss_event),
        .silent_upgrade (silent_upgrade),
        .transfer_event (transfer_event),
        .line_state     (line_state)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Applies one message to the predicted line and gives the result that the
    // block must produce for it. Illegal messages keep the state as it is.
    task automatic advance_line(input msg_t m, output result_t r);
        line_state_t st;
        bus_req_t    req;
        logic        is_store;
        logic        is_getm;
        logic        for_this_node;
        logic        to_proc;
        logic        on_bus;
        logic        sh_out;
        logic        err;
        logic        miss;
        logic        upg;
        logic        xfer;

        st            = line_coh_state;
        req           = REQ_NONE;
        is_store      = (m.operation == OP_STORE);
        is_getm       = (m.operation == OP_GETM);
        for_this_node = (m.dest_node == line_node_id);
        to_proc       = 1'b0;
        on_bus        = 1'b0;
        sh_out        = 1'b0;
        err           = 1'b0;
        miss          = 1'b0;
        upg           = 1'b0;
        xfer          = 1'b0;

        case (m.operation)
            OP_LOAD, OP_STORE:
            begin
                case (st)
                    ST_I:
                    begin
                        req  = is_store ? REQ_GETM : REQ_GETS;
                        st   = is_store ? ST_IM : ST_IS;
                        miss = 1'b1;
                    end
                    ST_S, ST_O, ST_F:
                    begin
                        if (is_store)
                        begin
                            req  = REQ_GETM;
                            miss = 1'b1;
                            case (st)
                                ST_S:    st = ST_SM;
                                ST_O:    st = ST_OM;
                                default: st = ST_FM;
                            endcase
                        end
                        else
                        begin
                            to_proc = 1'b1;
                        end
                    end
                    ST_E:
                    begin
                        to_proc = 1'b1;
                        if (is_store)
                        begin
                            st  = ST_M;
                            upg = 1'b1;
                        end
                    end
                    ST_M:
                    begin
                        to_proc = 1'b1;
                    end
                    default:
                    begin
                        // A processor access while a miss is outstanding.
                        err = 1'b1;
                    end
                endcase
            end
            OP_GETS, OP_GETM:
            begin
                case (st)
                    ST_S:
                    begin
                        if (is_getm)
                            st = ST_I;
                        else
                            sh_out = 1'b1;
                    end
                    ST_M, ST_E, ST_O, ST_F:
                    begin
                        on_bus = 1'b1;
                        xfer   = 1'b1;
                        if (is_getm)
                        begin
                            st = ST_I;
                        end
                        else
                        begin
                            sh_out = 1'b1;
                            if (st == ST_M)
                                st = ST_O;
                            else if (st == ST_E)
                                st = ST_F;
                        end
                    end
                    ST_OM, ST_FM:
                    begin
                        // The owner still supplies data while its upgrade waits.
                        on_bus = 1'b1;
                        xfer   = 1'b1;
                        if (is_getm)
                            st = ST_IM;
                        else
                            sh_out = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_DATA:
            begin
                case (st)
                    ST_M:
                    begin
                        err = 1'b1;
                    end
                    ST_IS:
                    begin
                        if (for_this_node)
                        begin
                            to_proc = 1'b1;
                            st      = m.shared_in ? ST_S : ST_E;
                        end
                    end
                    ST_IM, ST_SM, ST_OM, ST_FM:
                    begin
                        if (for_this_node)
                        begin
                            to_proc = 1'b1;
                            st      = ST_M;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                err = 1'b1;
            end
        endcase

        line_coh_state   = st;
        r.bus_request    = req;
        r.data_to_proc   = to_proc;
        r.data_on_bus    = on_bus;
        r.data_target    = on_bus ? m.source_node : '0;
        r.addr_out       = (req != REQ_NONE || to_proc || on_bus) ? m.line_address : '0;
        r.assert_shared  = sh_out;
        r.protocol_error = err;
        r.miss_event     = miss;
        r.silent_upgrade = upg;
        r.transfer_event = xfer;
        r.line_state     = st;
    endtask

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            if (n_fail < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            n_fail++;
        end
    endfunction

    function automatic void push_msg(logic [2:0] op, logic [31:0] a, logic [3:0] s,
                                     logic [3:0] d, logic sh);
        msg_t m;

        m.operation    = op;
        m.line_address = a;
        m.source_node  = s;
        m.dest_node    = d;
        m.shared_in    = sh;
        pending_msgs.push_back(m);
    endfunction

    // Sender. A new message goes out only once the previous one has been
    // transferred; the prediction is made at the edge of the transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                advance_line(cur_msg, predicted_res);
                owed_results.push_back(predicted_res);
                n_sent++;
            end
            if (in_valid && !in_ready)
                n_in_stalls++;
            if (!in_valid || in_ready)
            begin
                if (pending_msgs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_msg      = pending_msgs.pop_front();
                    in_valid     <= 1'b1;
                    operation    <= cur_msg.operation;
                    line_address <= cur_msg.line_address;
                    source_node  <= cur_msg.source_node;
                    dest_node    <= cur_msg.dest_node;
                    shared_in    <= cur_msg.shared_in;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // The long hold-off counts its own cycles from the moment it is requested,
    // so the receiver sits still while the sender keeps offering messages.
    always @(posedge clk)
    begin
        if (!hold_req)
            hold_cnt <= 0;
        else if (hold_cnt < HOLD_LEN)
            hold_cnt <= hold_cnt + 1;
    end

    assign long_hold = hold_req && (hold_cnt < HOLD_LEN);

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker. Every transfer on the output channel must match the
    // oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                if (n_fail < MAX_REPORTS)
                    $display("%0t: result with no message outstanding, line_state %0h",
                             $time, line_state);
                n_fail++;
            end
            else
            begin
                want = owed_results.pop_front();
                check_field("bus_request", 32'(want.bus_request), 32'(bus_request));
                check_field("data_to_proc", 32'(want.data_to_proc), 32'(data_to_proc));
                check_field("data_on_bus", 32'(want.data_on_bus), 32'(data_on_bus));
                check_field("data_target", 32'(want.data_target), 32'(data_target));
                check_field("addr_out", want.addr_out, addr_out);
                check_field("assert_shared", 32'(want.assert_shared), 32'(assert_shared));
                check_field("protocol_error", 32'(want.protocol_error),
                            32'(protocol_error));
                check_field("miss_event", 32'(want.miss_event), 32'(miss_event));
                check_field("silent_upgrade", 32'(want.silent_upgrade),
                            32'(silent_upgrade));
                check_field("transfer_event", 32'(want.transfer_event),
                            32'(transfer_event));
                check_field("line_state", 32'(want.line_state), 32'(line_state));
                states_seen[want.line_state] = 1'b1;
                n_checked++;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Waits until every message has been transferred and every owed result
    // has come back. The extra cycles cover the two-stage pipeline.
    task automatic drain();
        while (pending_msgs.size() != 0 || in_valid || owed_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_node_id(input logic [3:0] id);
        @(posedge clk);
        cfg_we       <= 1'b1;
        cfg_wdata    <= id;
        line_node_id = id;
        @(posedge clk);
        cfg_we       <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge clk);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Walks the line through every state, starting from Invalid with node id 0.
    task automatic queue_directed();
        // Undefined operation codes are flagged and change nothing.
        push_msg(OP_RSVD5, 32'hFFFF_FFFF, 4'hF, 4'hF, 1'b1);
        push_msg(OP_RSVD6, 32'h0000_0000, 4'h0, 4'h0, 1'b0);
        push_msg(OP_RSVD7, 32'hFFFF_FFFF, 4'hF, 4'h0, 1'b1);
        // Snoops and stray data in Invalid are ignored.
        push_msg(OP_GETS, 32'hFFFF_FFFF, 4'hF, 4'h0, 1'b0);
        push_msg(OP_DATA, 32'h0000_0000, 4'h0, 4'h0, 1'b1);
        // Load miss; a processor access and a snoop while the miss is open.
        push_msg(OP_LOAD, 32'h0000_0000, 4'h0, 4'h0, 1'b0);
        push_msg(OP_STORE, 32'hFFFF_FFFF, 4'hF, 4'hF, 1'b1);
        push_msg(OP_GETM, 32'h1234_5678, 4'h5, 4'h0, 1'b0);
        // Data for another node is ignored, then unshared data gives E.
        push_msg(OP_DATA, 32'h0000_0000, 4'h3, 4'h9, 1'b0);
        push_msg(OP_DATA, 32'h0000_0000, 4'h3, 4'h0, 1'b0);
        // E supplies data on GETS and becomes F, then upgrades through FM.
        push_msg(OP_GETS, 32'hFFFF_FFFF, 4'hF, 4'h0, 1'b0);
        push_msg(OP_LOAD, 32'h0000_0000, 4'h0, 4'h0, 1'b0);
        push_msg(OP_STORE, 32'hFFFF_FFFF, 4'h0, 4'h0, 1'b0);
        push_msg(OP_GETS, 32'hA5A5_A5A5, 4'h0, 4'h0, 1'b0);
        push_msg(OP_GETM, 32'h5A5A_5A5A, 4'h7, 4'h0, 1'b0);
        push_msg(OP_DATA, 32'hFFFF_FFFF, 4'h2, 4'h0, 1'b1);
        // DATA while in M is illegal; GETS moves M to O.
        push_msg(OP_DATA, 32'h0000_0000, 4'h2, 4'h0, 1'b0);
        push_msg(OP_GETS, 32'hFFFF_FFFF, 4'h3, 4'h0, 1'b0);
        push_msg(OP_STORE, 32'h0000_0000, 4'h0, 4'h0, 1'b0);
        push_msg(OP_LOAD, 32'h0000_0000, 4'h0, 4'h0, 1'b0);
        push_msg(OP_DATA, 32'h0000_0000, 4'h1, 4'h0, 1'b0);
        push_msg(OP_GETM, 32'hFFFF_FFFF, 4'hE, 4'h0, 1'b0);
        // Shared fill gives S, then an upgrade through SM.
        push_msg(OP_LOAD, 32'hFFFF_FFFF, 4'h0, 4'h0, 1'b0);
        push_msg(OP_DATA, 32'hFFFF_FFFF, 4'h6, 4'h0, 1'b1);
        push_msg(OP_GETS, 32'h0000_0000, 4'h8, 4'h0, 1'b0);
        push_msg(OP_STORE, 32'h0000_0000, 4'h0, 4'h0, 1'b0);
        push_msg(OP_DATA, 32'h0000_0000, 4'h6, 4'h0, 1'b1);
        // Back to E, then a store upgrades it without a bus request.
        push_msg(OP_GETM, 32'h0000_0000, 4'h4, 4'h0, 1'b0);
        push_msg(OP_LOAD, 32'hFFFF_FFFF, 4'h0, 4'h0, 1'b0);
        push_msg(OP_DATA, 32'hFFFF_FFFF, 4'h6, 4'h0, 1'b0);
        push_msg(OP_STORE, 32'hFFFF_FFFF, 4'h0, 4'h0, 1'b0);
    endtask

    // Mostly whole transactions with random content, plus standalone snoops
    // and noise with any operation code. DATA usually targets this node so
    // that outstanding misses complete.
    task automatic queue_random_traffic(input int n_items);
        int          n;
        int          k;
        int          pick;
        logic [31:0] a;
        logic [3:0]  d;

        n = 0;
        while (n < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                a = $urandom();
                push_msg($urandom_range(1) ? OP_STORE : OP_LOAD, a, 4'($urandom_range(15)),
                         4'($urandom_range(15)), 1'($urandom_range(1)));
                k = $urandom_range(2);
                repeat (k)
                    push_msg($urandom_range(1) ? OP_GETM : OP_GETS, $urandom(),
                             4'($urandom_range(15)), 4'($urandom_range(15)),
                             1'($urandom_range(1)));
                d = ($urandom_range(99) < 85) ? line_node_id : 4'($urandom_range(15));
                push_msg(OP_DATA, a, 4'($urandom_range(15)), d, 1'($urandom_range(1)));
                n += k + 2;
            end
            else if (pick < 80)
            begin
                k = $urandom_range(3, 1);
                repeat (k)
                    push_msg($urandom_range(1) ? OP_GETM : OP_GETS, $urandom(),
                             4'($urandom_range(15)), 4'($urandom_range(15)),
                             1'($urandom_range(1)));
                n += k;
            end
            else
            begin
                push_msg(3'($urandom_range(7)), $urandom(), 4'($urandom_range(15)),
                         4'($urandom_range(15)), 1'($urandom_range(1)));
                n++;
            end
        end
    endtask

    initial
    begin
        logic [3:0] mid_id;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk with no idling on either side.
        write_node_id(4'h0);
        set_idling(0, 0);
        @(negedge clk);
        queue_directed();
        drain();

        // Random traffic at full rate, highest node id.
        write_node_id(4'hF);
        @(negedge clk);
        queue_random_traffic(400);
        drain();

        // Sender idles often.
        mid_id = 4'($urandom_range(14, 1));
        write_node_id(mid_id);
        set_idling(45, 0);
        @(negedge clk);
        queue_random_traffic(400);
        drain();

        // Receiver stalls often. The phase opens with a long hold-off so that
        // the block backs up and stops taking new messages.
        write_node_id(4'h0);
        set_idling(0, 45);
        @(posedge clk);
        hold_req <= 1'b1;
        @(negedge clk);
        queue_random_traffic(450);
        drain();
        @(posedge clk);
        hold_req <= 1'b0;

        // Both sides idle.
        write_node_id(4'hF);
        set_idling(34, 34);
        @(negedge clk);
        queue_random_traffic(450);
        drain();

        $display("Run covered %0d messages and %0d checked results over five phases",
                 n_sent, n_checked);
        $display("with node ids 0, 15 and %0d; %0d of 11 line states reached,",
                 mid_id, $countones(states_seen));
        $display("input stalled %0d cycles", n_in_stalls);
        if (n_fail == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
